@@ sv/gamepad_event_button_mapper_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef GAMEPAD_EVENT_BUTTON_MAPPER_CORE_ASSERT_SVH
`define GAMEPAD_EVENT_BUTTON_MAPPER_CORE_ASSERT_SVH
`define GEBM_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define GEBM_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

@@ sv/gebm_pkg.sv @@
// ----------------------------------------------------------------------------
// gebm_pkg
// Shared types and constants of the gamepad event button mapper.
// ----------------------------------------------------------------------------
package gebm_pkg;
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_IGNORE = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   localparam logic [1:0] MODE_BUTTON = 2'd0;
   localparam logic [1:0] MODE_AXIS   = 2'd1;
   localparam logic [1:0] MODE_HAT    = 2'd2;

   localparam logic [15:0] BTN_LEFT  = 16'h0001;
   localparam logic [15:0] BTN_RIGHT = 16'h0002;
   localparam logic [15:0] BTN_UP    = 16'h0004;
   localparam logic [15:0] BTN_DOWN  = 16'h0008;

   localparam logic signed [31:0] HAT_HIGH = 32'sd7;
   localparam logic signed [31:0] AXIS_LOW = -32'sd1;

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        event_type;
      logic [15:0]        event_code;
      logic [31:0]        event_value;
      logic [15:0]        entry_mask;
      logic signed [31:0] entry_low;
      logic signed [31:0] entry_high;
   } item_type;

   typedef struct packed {
      logic [15:0] buttons;
      logic        buttons_changed;
      logic [1:0]  status;
   } result_type;

   // hat direction: 2 bits, [1] negative, [0] positive
   function automatic logic [1:0] hat_x(input logic [31:0] p);
      logic [1:0] r;
      r = 2'b00;
      if (p == 32'd5 || p == 32'd6 || p == 32'd7) r = 2'b10;
      if (p == 32'd1 || p == 32'd2 || p == 32'd3) r = 2'b01;
      return r;
   endfunction

   function automatic logic [1:0] hat_y(input logic [31:0] p);
      logic [1:0] r;
      r = 2'b00;
      if (p == 32'd7 || p == 32'd0 || p == 32'd1) r = 2'b10;
      if (p == 32'd3 || p == 32'd4 || p == 32'd5) r = 2'b01;
      return r;
   endfunction
endpackage

@@ sv/gebm_queue.sv @@
// ----------------------------------------------------------------------------
// gebm_queue
// Two-entry queue of packed words with full/empty flags.
// ----------------------------------------------------------------------------
module gebm_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       cnt_ff;
   logic             do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) data_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule

@@ sv/gebm_back.sv @@
// ----------------------------------------------------------------------------
// gebm_back
// Mapping table and button bitmap; carries out one item per cycle while the output side is ready.
// ----------------------------------------------------------------------------
module gebm_back import gebm_pkg::*; #(
   parameter int MAP_ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  item_type   in_item,
   output logic       in_ready,
   output logic       out_valid,
   output result_type out_result,
   input  logic       out_ready
);
   localparam int CW = $clog2(MAP_ENTRIES + 1);
   localparam int IW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

   logic [15:0]        ktype_ff [MAP_ENTRIES];
   logic [15:0]        kcode_ff [MAP_ENTRIES];
   logic [15:0]        mask_ff  [MAP_ENTRIES];
   logic [1:0]         mode_ff  [MAP_ENTRIES];
   logic signed [31:0] lo_ff    [MAP_ENTRIES];
   logic signed [31:0] hi_ff    [MAP_ENTRIES];
   logic [31:0]        raw_ff   [MAP_ENTRIES];
   logic [31:0]        last_ff  [MAP_ENTRIES];
   logic [CW-1:0]      count_ff;
   logic [15:0]        buttons_ff, buttons_in;
   logic               valid_ff;
   result_type         res_ff, res_in;

   logic            hit;
   logic [IW-1:0]   hit_idx;
   logic            go, add_ok, ev_upd;
   logic [1:0]      new_mode;
   logic signed [31:0] new_lo, new_hi;
   logic [31:0]     new_last;
   logic [15:0]     m, blo, bhi;
   logic [31:0]     old, hv;
   logic signed [31:0] sv;
   logic [1:0]      nx, ny, px, py;

   assign in_ready   = !valid_ff || out_ready;
   assign go         = in_valid && in_ready;
   assign out_valid  = valid_ff;
   assign out_result = res_ff;

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      for (int i = MAP_ENTRIES - 1; i >= 0; i--) begin
         if (CW'(i) < count_ff && ktype_ff[i] == in_item.event_type &&
             kcode_ff[i] == in_item.event_code) begin
            hit = 1'b1;
            hit_idx = IW'(i);
         end
      end
   end

   always_comb begin
      new_mode = MODE_BUTTON;
      new_lo   = in_item.entry_low;
      new_hi   = in_item.entry_high;
      if (in_item.entry_mask == (BTN_LEFT | BTN_RIGHT | BTN_UP | BTN_DOWN)) begin
         new_mode = MODE_HAT;
         if (new_lo == new_hi) begin
            new_lo = '0;
            new_hi = HAT_HIGH;
         end
      end else if (in_item.entry_mask == (BTN_LEFT | BTN_RIGHT) ||
                   in_item.entry_mask == (BTN_UP | BTN_DOWN)) begin
         new_mode = MODE_AXIS;
         if (new_lo == new_hi) begin
            new_lo = AXIS_LOW;
            new_hi = -AXIS_LOW;
         end
      end
   end

   always_comb begin
      buttons_in = buttons_ff;
      add_ok     = 1'b0;
      ev_upd     = 1'b0;
      new_last   = last_ff[hit_idx];
      res_in.status = ST_DONE;
      m   = mask_ff[hit_idx];
      old = last_ff[hit_idx];
      blo = (BTN_LEFT | BTN_UP) & m;
      bhi = (BTN_RIGHT | BTN_DOWN) & m;
      sv  = in_item.event_value;
      hv  = in_item.event_value - lo_ff[hit_idx];
      nx = hat_x(hv);
      ny = hat_y(hv);
      px = hat_x(old);
      py = hat_y(old);
      unique case (in_item.operation)
         OP_ADD: begin
            if (in_item.event_type == 16'd0 || count_ff >= CW'(MAP_ENTRIES) || hit)
               res_in.status = ST_REJECT;
            else
               add_ok = 1'b1;
         end
         OP_EVENT: begin
            if (!hit || raw_ff[hit_idx] == in_item.event_value) begin
               res_in.status = ST_IGNORE;
            end else begin
               ev_upd = 1'b1;
               unique case (mode_ff[hit_idx])
                  MODE_AXIS: begin
                     if (sv <= lo_ff[hit_idx]) new_last = 32'hFFFF_FFFF;
                     else if (sv >= hi_ff[hit_idx]) new_last = 32'd1;
                     else new_last = '0;
                     if (new_last != old) begin
                        if (old[31]) buttons_in = buttons_in & ~blo;
                        else if (old != 32'd0) buttons_in = buttons_in & ~bhi;
                        if (new_last[31]) buttons_in = buttons_in | blo;
                        else if (new_last != 32'd0) buttons_in = buttons_in | bhi;
                     end
                  end
                  MODE_HAT: begin
                     new_last = hv;
                     if (hv != old) begin
                        if (nx != px) begin
                           if (px[1]) buttons_in = buttons_in & ~BTN_LEFT;
                           if (px[0]) buttons_in = buttons_in & ~BTN_RIGHT;
                           if (nx[1]) buttons_in = buttons_in | BTN_LEFT;
                           if (nx[0]) buttons_in = buttons_in | BTN_RIGHT;
                        end
                        if (ny != py) begin
                           if (py[1]) buttons_in = buttons_in & ~BTN_UP;
                           if (py[0]) buttons_in = buttons_in & ~BTN_DOWN;
                           if (ny[1]) buttons_in = buttons_in | BTN_UP;
                           if (ny[0]) buttons_in = buttons_in | BTN_DOWN;
                        end
                     end
                  end
                  default: begin
                     new_last = {31'd0, in_item.event_value != 32'd0};
                     if (new_last != old) begin
                        if (new_last[0]) buttons_in = buttons_in | m;
                        else buttons_in = buttons_in & ~m;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
      res_in.buttons = buttons_in;
      res_in.buttons_changed = buttons_in != buttons_ff;
   end

   always_ff @(posedge clock) begin
      if (go) begin
         res_ff <= res_in;
         if (add_ok) begin
            ktype_ff[count_ff[IW-1:0]] <= in_item.event_type;
            kcode_ff[count_ff[IW-1:0]] <= in_item.event_code;
            mask_ff[count_ff[IW-1:0]]  <= in_item.entry_mask;
            mode_ff[count_ff[IW-1:0]]  <= new_mode;
            lo_ff[count_ff[IW-1:0]]    <= new_lo;
            hi_ff[count_ff[IW-1:0]]    <= new_hi;
            raw_ff[count_ff[IW-1:0]]   <= '0;
            last_ff[count_ff[IW-1:0]]  <= '0;
         end
         if (ev_upd) begin
            raw_ff[hit_idx]  <= in_item.event_value;
            last_ff[hit_idx] <= new_last;
         end
      end
      if (reset) begin
         valid_ff   <= 1'b0;
         count_ff   <= '0;
         buttons_ff <= '0;
      end else begin
         if (go) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
         if (go) begin
            buttons_ff <= buttons_in;
            if (in_item.operation == OP_CLEAR) count_ff <= '0;
            else if (add_ok) count_ff <= count_ff + CW'(1);
         end
      end
   end
endmodule

@@ sv/gamepad_event_button_mapper_core.sv @@
// Path: an accepted item is registered in the input queue, the table stage and the result queue
// before its result reaches the ports.
// Throughput: one item per cycle while the result queue has room, set by the table match and update.
// Reset: synchronous; empties both queues, clears entry count and button bitmap.
// ----------------------------------------------------------------------------
// gamepad_event_button_mapper_core
// Input queue front, mapping back end, result queue.
// ----------------------------------------------------------------------------
module gamepad_event_button_mapper_core import gebm_pkg::*; #(
   parameter int MAP_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_operation,
   input  logic [15:0]        req_event_type,
   input  logic [15:0]        req_event_code,
   input  logic signed [31:0] req_event_value,
   input  logic [15:0]        req_entry_mask,
   input  logic signed [31:0] req_entry_low,
   input  logic signed [31:0] req_entry_high,
   output logic               empty,
   input  logic               pop,
   output logic [15:0]        rsp_buttons,
   output logic               rsp_buttons_changed,
   output logic [1:0]         rsp_status
);
   item_type   in_item, q_item;
   result_type b_res, o_res;
   logic q_empty, b_ready, b_valid, r_full;

   assign in_item = '{req_operation, req_event_type, req_event_code, req_event_value,
                      req_entry_mask, req_entry_low, req_entry_high};

   gebm_queue #(.WIDTH($bits(item_type))) u_in_q (
      .clock, .reset, .push, .push_data(in_item), .full,
      .pop(b_ready), .pop_data(q_item), .empty(q_empty));

   gebm_back #(.MAP_ENTRIES(MAP_ENTRIES)) u_back (
      .clock, .reset, .in_valid(!q_empty), .in_item(q_item), .in_ready(b_ready),
      .out_valid(b_valid), .out_result(b_res), .out_ready(!r_full));

   gebm_queue #(.WIDTH($bits(result_type))) u_out_q (
      .clock, .reset, .push(b_valid), .push_data(b_res), .full(r_full),
      .pop, .pop_data(o_res), .empty);

   assign rsp_buttons         = o_res.buttons;
   assign rsp_buttons_changed = o_res.buttons_changed;
   assign rsp_status          = o_res.status;
endmodule

@@ sv/gebm_checker.sv @@
// ----------------------------------------------------------------------------
// gebm_checker
// Port-level checks of the mapper core.
// ----------------------------------------------------------------------------
`include "gamepad_event_button_mapper_core_assert.svh"
module gebm_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [15:0] rsp_buttons,
   input logic        rsp_buttons_changed,
   input logic [1:0]  rsp_status
);
   `GEBM_ASSERT_IMP(a_status_range, clock, reset, !empty, rsp_status != 2'd3)
   `GEBM_ASSERT_IMP(a_reject_nochg, clock, reset, !empty && rsp_status == 2'd2,
      !rsp_buttons_changed)
   `GEBM_ASSERT_NXT(a_hold, clock, reset, !empty && !pop,
      !empty && $stable(rsp_buttons) && $stable(rsp_status))
   `GEBM_ASSERT_NXT(a_rst_empty, clock, 1'b0, reset, empty && !full)
endmodule

bind gamepad_event_button_mapper_core gebm_checker u_gebm_checker (
   .clock, .reset, .full, .empty, .pop,
   .rsp_buttons, .rsp_buttons_changed, .rsp_status);
